@@ rtl/core/rhb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhb_pkg
// Shared types, register indexes and helper functions of the color histogram.
// ----------------------------------------------------------------------------
package rhb_pkg;

  localparam logic [1:0] REG_RED_SHIFT   = 2'd0;
  localparam logic [1:0] REG_GREEN_SHIFT = 2'd1;
  localparam logic [1:0] REG_BLUE_SHIFT  = 2'd2;

  localparam logic       KIND_PIXEL = 1'b0;
  localparam logic       KIND_NEXT  = 1'b1;

  localparam logic [3:0]  SHIFT_RESET   = 4'd4;
  localparam logic [3:0]  SHIFT_TOP     = 4'd8;
  localparam logic [12:0] OCC_MAX       = 13'h1FFF;
  localparam logic [31:0] PIX_MAX       = 32'hFFFF_FFFF;
  localparam logic [31:0] OUT_COUNT_MAX = 32'h00FF_FFFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  red_center;
    logic [7:0]  green_center;
    logic [7:0]  blue_center;
    logic [23:0] bin_count;
    logic [12:0] occupied_total;
    logic [31:0] pixel_total;
  } out_item_t;

  typedef struct packed {
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
  } shift_cfg_t;

  function automatic logic [3:0] eff_shift(input logic [3:0] s, input logic [3:0] min_s);
    logic [3:0] r;
    r = s;
    if (r < min_s) r = min_s;
    if (r > SHIFT_TOP) r = SHIFT_TOP;
    return r;
  endfunction

  function automatic logic [7:0] centre_of(input logic [7:0] idx, input logic [3:0] s);
    logic [15:0] t;
    t = ({8'd0, idx} << s) + (16'd1 << (s - 4'd1));
    return t[7:0];
  endfunction

endpackage

@@ rtl/core/rhb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rhb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/rhb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhb_front
// Accepts requests, forms the bin address and queues them for the back end.
// ----------------------------------------------------------------------------
module rhb_front #(
  parameter int MIN_SHIFT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rhb_pkg::in_item_t             in_data,
  input  rhb_pkg::shift_cfg_t           shifts,
  input  logic                          hold,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic                          q_kind,
  output logic [3*(8-MIN_SHIFT)-1:0]    q_addr
);

  localparam int IDX_BITS = 8 - MIN_SHIFT;
  localparam int ADDR_W   = 3 * IDX_BITS;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;

  logic              kinds [QDEPTH];
  logic [ADDR_W-1:0] addrs [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  logic [7:0]        r_idx;
  logic [7:0]        g_idx;
  logic [7:0]        b_idx;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    r_idx = in_data.red   >> shifts.red;
    g_idx = in_data.green >> shifts.green;
    b_idx = in_data.blue  >> shifts.blue;
    addr  = {r_idx[IDX_BITS-1:0], g_idx[IDX_BITS-1:0], b_idx[IDX_BITS-1:0]};
  end

  assign in_stall = hold || (count == (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_kind   = kinds[rd_ptr];
  assign q_addr   = addrs[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      kinds[wr_ptr] <= in_data.kind;
      addrs[wr_ptr] <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

@@ rtl/core/rhb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhb_back
// Bin store, pixel read-modify-write pipe, occupied-bin scan and result reg.
// ----------------------------------------------------------------------------
module rhb_back #(
  parameter int MIN_SHIFT  = 4,
  parameter int COUNT_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rhb_pkg::shift_cfg_t        shifts,
  output logic                       clearing,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  logic                       q_kind,
  input  logic [3*(8-MIN_SHIFT)-1:0] q_addr,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rhb_pkg::out_item_t         out_data
);

  localparam int IDX_BITS = 8 - MIN_SHIFT;
  localparam int ADDR_W   = 3 * IDX_BITS;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam logic [ADDR_W:0]     SCAN_END  = {1'b1, {ADDR_W{1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                state;
  logic [ADDR_W-1:0]     clr_addr;
  logic                  b_valid;
  logic [ADDR_W-1:0]     b_addr;
  logic                  fwd_hit;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [ADDR_W:0]       scan_pos;
  logic [ADDR_W:0]       iss;
  logic                  pend;
  logic [12:0]           occ;
  logic [31:0]           pix;

  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  logic                  pop_pix;
  logic                  pop_next;
  logic [COUNT_BITS-1:0] old_count;
  logic [COUNT_BITS-1:0] new_count;
  logic                  hit_found;
  logic                  scan_done;
  logic                  scan_issue;
  logic [ADDR_W-1:0]     found_addr;
  logic [31:0]           count32;
  logic [23:0]           count_out;

  always_comb begin
    pop_pix  = 1'b0;
    pop_next = 1'b0;
    if (!clearing && q_valid && (state == ST_IDLE)) begin
      if (q_kind == rhb_pkg::KIND_PIXEL) begin
        pop_pix = 1'b1;
      end else if (!b_valid && !out_valid) begin
        pop_next = 1'b1;
      end
    end
  end
  assign q_pop = pop_pix || pop_next;

  // pixel read-modify-write
  assign old_count = fwd_hit ? fwd_data : rd_data;
  assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;

  // scan
  assign hit_found  = (state == ST_SCAN) && pend && (rd_data != '0);
  assign scan_done  = (state == ST_SCAN) && !hit_found && (iss == SCAN_END);
  assign scan_issue = (state == ST_SCAN) && !hit_found && (iss != SCAN_END);
  assign found_addr = iss[ADDR_W-1:0] - ADDR_W'(1);
  assign count32    = 32'(rd_data);
  assign count_out  = (count32 > rhb_pkg::OUT_COUNT_MAX) ? 24'hFF_FFFF : count32[23:0];

  always_comb begin
    rd_en   = pop_pix || scan_issue;
    rd_addr = pop_pix ? q_addr : iss[ADDR_W-1:0];
    wr_en   = clearing || b_valid;
    wr_addr = clearing ? clr_addr : b_addr;
    wr_data = clearing ? '0 : new_count;
  end

  rhb_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      state    <= ST_IDLE;
      b_valid  <= 1'b0;
      fwd_hit  <= 1'b0;
      scan_pos <= '0;
      iss      <= '0;
      pend     <= 1'b0;
      occ      <= '0;
      pix      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == {ADDR_W{1'b1}}) clearing <= 1'b0;
      end

      b_valid <= pop_pix;
      b_addr  <= q_addr;
      fwd_hit <= pop_pix && b_valid && (b_addr == q_addr);
      fwd_data <= new_count;

      if (b_valid) begin
        if ((old_count == '0) && (occ != rhb_pkg::OCC_MAX)) occ <= occ + 1'b1;
        if (pix != rhb_pkg::PIX_MAX) pix <= pix + 1'b1;
      end

      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (pop_next) begin
            state <= ST_SCAN;
            iss   <= scan_pos;
            pend  <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (hit_found) begin
            scan_pos  <= iss;
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end else if (scan_done) begin
            scan_pos  <= SCAN_END;
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end else begin
            iss  <= iss + 1'b1;
            pend <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hit_found || scan_done) begin
      out_data.found          <= hit_found;
      out_data.occupied_total <= occ;
      out_data.pixel_total    <= pix;
      if (hit_found) begin
        out_data.red_center   <= rhb_pkg::centre_of(
          8'(found_addr[ADDR_W-1 -: IDX_BITS]), shifts.red);
        out_data.green_center <= rhb_pkg::centre_of(
          8'(found_addr[2*IDX_BITS-1 -: IDX_BITS]), shifts.green);
        out_data.blue_center  <= rhb_pkg::centre_of(
          8'(found_addr[IDX_BITS-1:0]), shifts.blue);
        out_data.bin_count    <= count_out;
      end else begin
        out_data.red_center   <= '0;
        out_data.green_center <= '0;
        out_data.blue_center  <= '0;
        out_data.bin_count    <= '0;
      end
    end
  end

  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("request taken during clearing pass");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (scan_pos <= SCAN_END) && (iss <= SCAN_END))
    else $error("scan pointer beyond store");

  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_SCAN))
    else $error("result without scan");

  a_scan_waits_pipe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !b_valid)
    else $error("scan overlaps pixel update");

endmodule

@@ rtl/core/rgb_histogram_binner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_histogram_binner
// Reduced 3-D color histogram: counts pixels per bin and reads back
// occupied bins in red-major order.
// ----------------------------------------------------------------------------
// pixel requests: one per cycle sustained outside a scan or the clearing pass,
//   no result; the bin update is written in the cycle after the request leaves
//   the 4-entry queue (read-modify-write on one RAM)
// next requests: the scan reads one bin per cycle from the store port;
//   waits for the pixel pipe to drain and for the previous result to be taken
// reset: synchronous; shifts return to 4, then a clearing pass over all
//   2**(3*(8-MIN_SHIFT)) bins (4096 by default) with in_stall held high
// ----------------------------------------------------------------------------
module rgb_histogram_binner #(
  parameter int MIN_SHIFT  = 4,
  parameter int COUNT_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rhb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rhb_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  localparam int ADDR_W = 3 * (8 - MIN_SHIFT);

  logic [3:0]          red_shift;
  logic [3:0]          green_shift;
  logic [3:0]          blue_shift;
  rhb_pkg::shift_cfg_t shifts;
  logic                clearing;
  logic                q_valid;
  logic                q_pop;
  logic                q_kind;
  logic [ADDR_W-1:0]   q_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_shift   <= rhb_pkg::SHIFT_RESET;
      green_shift <= rhb_pkg::SHIFT_RESET;
      blue_shift  <= rhb_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rhb_pkg::REG_RED_SHIFT:   red_shift   <= cfg_data;
        rhb_pkg::REG_GREEN_SHIFT: green_shift <= cfg_data;
        rhb_pkg::REG_BLUE_SHIFT:  blue_shift  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    shifts.red   = rhb_pkg::eff_shift(red_shift,   4'(MIN_SHIFT));
    shifts.green = rhb_pkg::eff_shift(green_shift, 4'(MIN_SHIFT));
    shifts.blue  = rhb_pkg::eff_shift(blue_shift,  4'(MIN_SHIFT));
  end

  rhb_front #(
    .MIN_SHIFT (MIN_SHIFT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .shifts   (shifts),
    .hold     (clearing),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_kind   (q_kind),
    .q_addr   (q_addr)
  );

  rhb_back #(
    .MIN_SHIFT  (MIN_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .shifts    (shifts),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_kind    (q_kind),
    .q_addr    (q_addr),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
